// ----- src/prp_pkg.sv -----
// Shared types and constants for the page replacement policy core.
`default_nettype none

package prp_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int MAX_PAGES  = 256;
  localparam int FRAME_W    = 6;
  localparam int PAGE_W     = 8;
  localparam int RND_W      = 31;
  localparam int COUNT_W    = 32;
  localparam int FCNT_W     = 7;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;

  // Random remainder unit: bits retired per cycle and remainder steps per fault.
  localparam int MOD_BITS   = 4;
  localparam int MOD_STEPS  = 8;
  localparam int MOD_CNT_W  = 3;

  // Policy codes.
  localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIFO   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK,
    ST_PICK,
    ST_FETCH,
    ST_COMMIT
  } prp_state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic walk_step;
    logic pick;
    logic fetch;
    logic commit;
  } prp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              mod_last;
    logic              walk_found;
    logic              out_free;
  } prp_sts_t;

endpackage

`default_nettype wire

// ----- src/prp_ctrl.sv -----
// Fault sequencer: steps each fault through victim selection, lookup and commit.
`default_nettype none

module prp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire prp_pkg::prp_sts_t sts,
  output prp_pkg::prp_cmd_t     cmd
);

  prp_pkg::prp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      prp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // invalid mode: beat is consumed and dropped
          case (sts.mode)
            prp_pkg::MODE_RANDOM: begin
              cmd.load   = 1'b1;
              state_next = prp_pkg::ST_MOD;
            end
            prp_pkg::MODE_FIFO: begin
              cmd.load   = 1'b1;
              state_next = prp_pkg::ST_PICK;
            end
            prp_pkg::MODE_SECOND: begin
              cmd.load   = 1'b1;
              state_next = prp_pkg::ST_WALK;
            end
            default: state_next = prp_pkg::ST_IDLE;
          endcase
        end
      end
      prp_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_next = prp_pkg::ST_PICK;
      end
      prp_pkg::ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = prp_pkg::ST_FETCH;
      end
      prp_pkg::ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_found) state_next = prp_pkg::ST_FETCH;
      end
      prp_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = prp_pkg::ST_COMMIT;
      end
      prp_pkg::ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = prp_pkg::ST_IDLE;
        end
      end
      default: state_next = prp_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/prp_datapath.sv -----
// Datapath: config registers, hand, marks, owner maps, remainder unit, result register.
`default_nettype none

module prp_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [prp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [prp_pkg::FCNT_W-1:0]        cfg_data,
  input  wire logic [prp_pkg::PAGE_W-1:0]        fault_page,
  input  wire logic [prp_pkg::RND_W-1:0]         random_value,
  input  wire prp_pkg::prp_cmd_t                 cmd,
  output prp_pkg::prp_sts_t                      sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [prp_pkg::FRAME_W-1:0]            victim_frame,
  output logic [prp_pkg::PAGE_W-1:0]             evicted_page,
  output logic                                   evicted_valid,
  output logic [prp_pkg::COUNT_W-1:0]            fault_total
);

  localparam int FW = prp_pkg::FRAME_W;
  localparam int PW = prp_pkg::PAGE_W;
  localparam int NW = prp_pkg::FCNT_W;

  // configuration
  logic [prp_pkg::MODE_W-1:0] policy_mode;
  logic [NW-1:0]              frame_count;

  // per-fault working registers
  logic [prp_pkg::MODE_W-1:0] cur_mode;
  logic [PW-1:0]              cur_page;
  logic [NW-1:0]              n_eff;
  logic [FW-1:0]              victim;
  logic [NW-1:0]              rem;
  logic [prp_pkg::RND_W:0]    dividend;
  logic [prp_pkg::MOD_CNT_W-1:0] mod_cnt;

  // persistent state
  logic [FW-1:0]                     hand;
  logic [prp_pkg::MAX_FRAMES-1:0]    owner_used;
  logic [prp_pkg::MAX_FRAMES-1:0]    chance_mark;
  logic [prp_pkg::MAX_PAGES-1:0]     page_valid;   // page resident, page_frame entry live
  logic [prp_pkg::COUNT_W-1:0]       fault_counter;

  logic [PW-1:0] owner_page [prp_pkg::MAX_FRAMES];
  logic [FW-1:0] page_frame [prp_pkg::MAX_PAGES];
  logic [PW-1:0] ev_data;
  logic [FW-1:0] rev_frame;

  logic [NW-1:0]                n_calc;
  logic [NW-1:0]                rem_next;
  logic [FW-1:0]                hand_adv;
  logic                         ev_hit;
  logic                         dup_hit;
  logic [prp_pkg::COUNT_W-1:0]  fault_counter_next;

  function automatic logic [FW-1:0] advance(input logic [FW-1:0] pos, input logic [NW-1:0] n);
    logic [NW-1:0] p1;
    p1 = {1'b0, pos} + 1'b1;
    return (p1 >= n) ? '0 : p1[FW-1:0];
  endfunction

  // frame_count clamped to 1..MAX_FRAMES
  always_comb begin
    if (frame_count == '0) begin
      n_calc = NW'(1);
    end else if (frame_count > NW'(prp_pkg::MAX_FRAMES)) begin
      n_calc = NW'(prp_pkg::MAX_FRAMES);
    end else begin
      n_calc = frame_count;
    end
  end

  // restoring remainder, MOD_BITS dividend bits per cycle
  always_comb begin
    logic [NW-1:0] r;
    r = rem;
    for (int i = 0; i < prp_pkg::MOD_BITS; i++) begin
      r = {r[NW-2:0], dividend[prp_pkg::RND_W - i]};
      if (r >= n_eff) r = r - n_eff;
    end
    rem_next = r;
  end

  assign hand_adv = advance(hand, n_eff);
  assign ev_hit   = owner_used[victim];
  assign dup_hit  = page_valid[cur_page] && (rev_frame != victim);
  assign fault_counter_next = (fault_counter == '1) ? fault_counter
                                                    : fault_counter + 1'b1;

  assign sts.mode       = policy_mode;
  assign sts.mod_last   = (mod_cnt == prp_pkg::MOD_CNT_W'(prp_pkg::MOD_STEPS - 1));
  assign sts.walk_found = !chance_mark[hand];
  assign sts.out_free   = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode   <= prp_pkg::MODE_FIFO;
      frame_count   <= NW'(prp_pkg::MAX_FRAMES);
      hand          <= '0;
      owner_used    <= '0;
      chance_mark   <= '0;
      page_valid    <= '0;
      fault_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          prp_pkg::REG_POLICY_MODE: policy_mode <= cfg_data[prp_pkg::MODE_W-1:0];
          prp_pkg::REG_FRAME_COUNT: frame_count <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.load && ({1'b0, hand} >= n_calc)) hand <= '0;

      if (cmd.walk_step) begin
        hand <= hand_adv;
        // set mark: clear it and move on; clear mark: take frame, mark it
        chance_mark[hand] <= !chance_mark[hand];
      end

      if (cmd.pick && (cur_mode != prp_pkg::MODE_RANDOM)) hand <= hand_adv;

      if (cmd.commit) begin
        if (dup_hit) owner_used[rev_frame] <= 1'b0;
        owner_used[victim] <= 1'b1;
        // victim already holding this page keeps it resident
        if (ev_hit && (ev_data != cur_page)) page_valid[ev_data] <= 1'b0;
        page_valid[cur_page] <= 1'b1;
        fault_counter <= fault_counter_next;
      end

      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_mode <= policy_mode;
      cur_page <= fault_page;
      n_eff    <= n_calc;
      rem      <= '0;
      dividend <= {1'b0, random_value};
      mod_cnt  <= '0;
    end
    if (cmd.mod_step) begin
      rem      <= rem_next;
      dividend <= dividend << prp_pkg::MOD_BITS;
      mod_cnt  <= mod_cnt + 1'b1;
    end
    if (cmd.walk_step && !chance_mark[hand]) victim <= hand;
    if (cmd.pick) begin
      victim <= (cur_mode == prp_pkg::MODE_RANDOM) ? rem[FW-1:0] : hand;
    end
    if (cmd.commit) begin
      victim_frame  <= victim;
      evicted_page  <= ev_hit ? ev_data : '0;
      evicted_valid <= ev_hit;
      fault_total   <= fault_counter_next;
    end
  end

  // owner map: frame -> page
  always_ff @(posedge clk) begin
    if (cmd.fetch) ev_data <= owner_page[victim];
    if (cmd.commit) owner_page[victim] <= cur_page;
  end

  // reverse map: page -> frame, live only where page_valid is set
  always_ff @(posedge clk) begin
    if (cmd.fetch) rev_frame <= page_frame[cur_page];
    if (cmd.commit) page_frame[cur_page] <= victim;
  end

endmodule

`default_nettype wire

// ----- src/page_replacement_policy_core.sv -----
// Top level of the page replacement policy core: sequencer plus datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one page fault per beat:
//   fault_page and random_value. Output channel (out_valid/out_ready) returns
//   one beat per handled fault: victim_frame, evicted_page, evicted_valid and
//   the saturating fault_total. The cfg channel writes policy_mode (index 0)
//   and frame_count (index 1); cfg_ready is always high. The user must send
//   writes only while the core is idle; the core does not enforce this.
//   Sequencing: the core works on one fault at a time and is ready
//   again the cycle after a result is loaded into the output register.
//     FIFO:          pick, fetch, commit.
//     random:        the remainder unit retires 4 bits of random_value
//                    per cycle, then pick, fetch, commit.
//     second chance: the hand walks one frame per cycle, clearing set
//                    marks until it finds a clear one; then fetch, commit.
//   The result shows on out_valid the cycle after the commit step.
//   A fault that arrives while policy_mode is 3 is taken and dropped.
//   Reset: mode FIFO, 64 frames, hand at 0, all frames free, count zero.
//   Stall: the output register holds its beat; a new fault is still taken
//   and worked, and waits at its commit step until the register frees.
`default_nettype none

module page_replacement_policy_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [prp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prp_pkg::FCNT_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [prp_pkg::PAGE_W-1:0]     fault_page,
  input  wire logic [prp_pkg::RND_W-1:0]      random_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [prp_pkg::FRAME_W-1:0]         victim_frame,
  output logic [prp_pkg::PAGE_W-1:0]          evicted_page,
  output logic                                evicted_valid,
  output logic [prp_pkg::COUNT_W-1:0]         fault_total
);

  prp_pkg::prp_cmd_t cmd;
  prp_pkg::prp_sts_t sts;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  prp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fault_page    (fault_page),
    .random_value  (random_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .victim_frame  (victim_frame),
    .evicted_page  (evicted_page),
    .evicted_valid (evicted_valid),
    .fault_total   (fault_total)
  );

  // Commit only into a free output register, and it must show next cycle.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit into occupied output register");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  // Sequencer issues at most one datapath command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mod_step, cmd.walk_step, cmd.pick, cmd.fetch, cmd.commit}))
    else $error("overlapping datapath commands");

  // A new fault is taken only when no earlier fault is in flight.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !(cmd.mod_step || cmd.walk_step || cmd.pick ||
                                 cmd.fetch || cmd.commit))
    else $error("fault accepted while another is in progress");

endmodule

`default_nettype wire
